FILE: design/tcpfsm_pkg.sv
// ----------------------------------------------------------------------------
// tcpfsm_pkg
// Shared types and constants for the TCP connection control unit: state and
// command encodings, the segment flag bits and the register map.
// ----------------------------------------------------------------------------
package tcpfsm_pkg;

  // Connection states, encoded as reported on out_state_out
  typedef enum logic [3:0] {
    ST_LISTENING    = 4'd0,
    ST_CONNECTING   = 4'd1,
    ST_SYN_RECEIVED = 4'd2,
    ST_ESTABLISHED  = 4'd3,
    ST_FIN_WAIT1    = 4'd4,
    ST_FIN_ACKED    = 4'd5,
    ST_CLOSE_WAIT   = 4'd6,
    ST_CLOSING      = 4'd7,
    ST_LAST_ACK     = 4'd8,
    ST_TIME_WAIT    = 4'd9,
    ST_CLOSED       = 4'd10
  } state_t;

  // Item commands
  typedef enum logic [1:0] {
    OP_SEGMENT = 2'd0,
    OP_LISTEN  = 2'd1,
    OP_CONNECT = 2'd2,
    OP_CLOSE   = 2'd3
  } opcode_t;

  // Flag bit positions and flag words
  localparam int unsigned FIN_BIT = 0;
  localparam int unsigned SYN_BIT = 1;
  localparam int unsigned RST_BIT = 2;
  localparam int unsigned ACK_BIT = 3;

  localparam logic [3:0] FLAGS_NONE    = 4'b0000;
  localparam logic [3:0] FLAGS_FIN     = 4'b0001;
  localparam logic [3:0] FLAGS_SYN     = 4'b0010;
  localparam logic [3:0] FLAGS_ACK     = 4'b1000;
  localparam logic [3:0] FLAGS_SYN_ACK = 4'b1010;

  // Register map (byte addresses)
  localparam int unsigned PADDR_W       = 3;
  localparam logic [PADDR_W-1:0] ADDR_INIT_SEQ = 3'd0;

endpackage

FILE: design/tcp_connection_fsm_unit.sv
// Result path: an accepted word waits in the input register, then moves to
// the result register once that one is empty or being taken. Throughput:
// one word per cycle while out_ready does not stall; the state update is a
// single pass of transition logic between input and state registers.
// Reset (rst_n low, synchronous): state closed, sequence, ack and peer port
// zero, initial_sequence zero, both channels empty.
// ----------------------------------------------------------------------------
// tcp_connection_fsm_unit
// Control state machine of one TCP connection. Takes user commands and
// arriving segments, returns the control segment to send, the new state,
// the delivery and wake marks, and the peer port.
// ----------------------------------------------------------------------------
module tcp_connection_fsm_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tcpfsm_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_opcode,
  input  logic [3:0]                       in_seg_flags,
  input  logic [31:0]                      in_seg_sequence,
  input  logic [31:0]                      in_seg_acknowledge,
  input  logic [15:0]                      in_seg_payload_length,
  input  logic [15:0]                      in_seg_source_port,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_send_valid,
  output logic [3:0]                       out_send_flags,
  output logic [31:0]                      out_send_sequence_out,
  output logic [31:0]                      out_send_acknowledge_out,
  output logic [3:0]                       out_state_out,
  output logic                             out_deliver_payload,
  output logic                             out_wake_caller,
  output logic [15:0]                      out_peer_port_out
);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [31:0] init_seq_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_seq_r <= '0;
    end else if (cfg_wr && (paddr[2] == tcpfsm_pkg::ADDR_INIT_SEQ[2])) begin
      init_seq_r <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == tcpfsm_pkg::ADDR_INIT_SEQ[2]) begin
      prdata = init_seq_r;
    end
  end

  // --------------------------------------------------------------------------
  // Input register and handshake
  // --------------------------------------------------------------------------
  logic                 s1_valid_r;
  tcpfsm_pkg::opcode_t  s1_op_r;
  logic [3:0]           s1_flags_r;
  logic [31:0]          s1_seq_r;
  logic [31:0]          s1_ack_r;
  logic [15:0]          s1_len_r;
  logic [15:0]          s1_port_r;
  logic                 out_valid_r;
  logic                 s1_adv;
  logic                 in_take;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r    <= tcpfsm_pkg::opcode_t'(in_opcode);
      s1_flags_r <= in_seg_flags;
      s1_seq_r   <= in_seg_sequence;
      s1_ack_r   <= in_seg_acknowledge;
      s1_len_r   <= in_seg_payload_length;
      s1_port_r  <= in_seg_source_port;
    end
  end

  // --------------------------------------------------------------------------
  // Connection state
  // --------------------------------------------------------------------------
  tcpfsm_pkg::state_t conn_state_r, conn_state_nxt;
  logic [31:0]        send_seq_r, send_seq_nxt;
  logic [31:0]        ack_num_r, ack_num_nxt;
  logic [15:0]        peer_port_r, peer_port_nxt;

  logic fin, syn, rst, ack;
  logic ack_load, port_load;
  logic emit, advance, deliver, wake;
  logic [3:0]  tx_flags;
  logic [31:0] seq_base;
  logic        est_data;
  logic        syn_ack_ok;

  assign fin = s1_flags_r[tcpfsm_pkg::FIN_BIT];
  assign syn = s1_flags_r[tcpfsm_pkg::SYN_BIT];
  assign rst = s1_flags_r[tcpfsm_pkg::RST_BIT];
  assign ack = s1_flags_r[tcpfsm_pkg::ACK_BIT];

  assign est_data   = (conn_state_r == tcpfsm_pkg::ST_ESTABLISHED) && (s1_len_r != 16'd0);
  assign syn_ack_ok = (s1_ack_r == (init_seq_r + 32'd1));

  // State reached by a user close
  function automatic tcpfsm_pkg::state_t close_target(tcpfsm_pkg::state_t cur);
    tcpfsm_pkg::state_t nxt;
    nxt = cur;
    unique case (cur) inside
      tcpfsm_pkg::ST_LISTENING,
      tcpfsm_pkg::ST_CONNECTING:   nxt = tcpfsm_pkg::ST_CLOSED;
      tcpfsm_pkg::ST_ESTABLISHED,
      tcpfsm_pkg::ST_SYN_RECEIVED: nxt = tcpfsm_pkg::ST_FIN_WAIT1;
      tcpfsm_pkg::ST_CLOSE_WAIT:   nxt = tcpfsm_pkg::ST_LAST_ACK;
      default:                     nxt = cur;
    endcase
    return nxt;
  endfunction

  // Next state, plus loads of ack number and peer port
  always_comb begin
    conn_state_nxt = conn_state_r;
    ack_load       = 1'b0;
    port_load      = 1'b0;
    unique case (s1_op_r)
      tcpfsm_pkg::OP_LISTEN:  conn_state_nxt = tcpfsm_pkg::ST_LISTENING;
      tcpfsm_pkg::OP_CONNECT: conn_state_nxt = tcpfsm_pkg::ST_CONNECTING;
      tcpfsm_pkg::OP_CLOSE:   conn_state_nxt = close_target(conn_state_r);
      default: begin
        if (!est_data) begin
          unique case (conn_state_r) inside
            tcpfsm_pkg::ST_LISTENING: begin
              if (syn && !rst && !fin) begin
                port_load      = 1'b1;
                ack_load       = 1'b1;
                conn_state_nxt = tcpfsm_pkg::ST_SYN_RECEIVED;
              end
            end
            tcpfsm_pkg::ST_CONNECTING: begin
              if (rst || fin) begin
                conn_state_nxt = tcpfsm_pkg::ST_CLOSED;
              end else if (syn && ack) begin
                if (syn_ack_ok) begin
                  ack_load       = 1'b1;
                  conn_state_nxt = tcpfsm_pkg::ST_ESTABLISHED;
                end else begin
                  conn_state_nxt = tcpfsm_pkg::ST_CLOSED;
                end
              end else begin
                conn_state_nxt = tcpfsm_pkg::ST_CLOSED;   // unexpected: acts as close
              end
            end
            tcpfsm_pkg::ST_SYN_RECEIVED: begin
              if (rst || fin) begin
                conn_state_nxt = tcpfsm_pkg::ST_CLOSED;
              end else if (ack) begin
                ack_load       = 1'b1;
                conn_state_nxt = tcpfsm_pkg::ST_ESTABLISHED;
              end else begin
                conn_state_nxt = tcpfsm_pkg::ST_CLOSED;
              end
            end
            tcpfsm_pkg::ST_ESTABLISHED: begin
              if (rst) begin
                conn_state_nxt = tcpfsm_pkg::ST_FIN_WAIT1;
              end else if (fin) begin
                conn_state_nxt = tcpfsm_pkg::ST_CLOSE_WAIT;
              end
            end
            tcpfsm_pkg::ST_FIN_WAIT1: begin
              if (fin && ack) begin
                conn_state_nxt = tcpfsm_pkg::ST_TIME_WAIT;
              end else if (ack) begin
                conn_state_nxt = tcpfsm_pkg::ST_FIN_ACKED;
              end else if (fin) begin
                conn_state_nxt = tcpfsm_pkg::ST_CLOSING;
              end
            end
            tcpfsm_pkg::ST_FIN_ACKED: begin
              if (fin) begin
                conn_state_nxt = tcpfsm_pkg::ST_TIME_WAIT;
              end
            end
            tcpfsm_pkg::ST_CLOSING,
            tcpfsm_pkg::ST_LAST_ACK: begin
              if (ack) begin
                conn_state_nxt = tcpfsm_pkg::ST_CLOSED;
              end
            end
            tcpfsm_pkg::ST_TIME_WAIT: conn_state_nxt = tcpfsm_pkg::ST_CLOSED;
            default: ;
          endcase
        end
      end
    endcase
  end

  // Outputs of the transition: segment to send, sequence advance, marks
  always_comb begin
    emit     = 1'b0;
    advance  = 1'b0;
    tx_flags = tcpfsm_pkg::FLAGS_NONE;
    deliver  = 1'b0;
    wake     = 1'b0;
    unique case (s1_op_r)
      tcpfsm_pkg::OP_LISTEN: ;
      tcpfsm_pkg::OP_CONNECT: begin
        emit     = 1'b1;
        advance  = 1'b1;
        tx_flags = tcpfsm_pkg::FLAGS_SYN;
      end
      tcpfsm_pkg::OP_CLOSE: begin
        if (conn_state_r != tcpfsm_pkg::ST_LISTENING) begin
          emit     = 1'b1;
          advance  = 1'b1;
          tx_flags = tcpfsm_pkg::FLAGS_FIN;
        end
      end
      default: begin
        if (est_data) begin
          deliver = 1'b1;
        end else begin
          unique case (conn_state_r)
            tcpfsm_pkg::ST_LISTENING: begin
              if (syn && !rst && !fin) begin
                emit     = 1'b1;
                advance  = 1'b1;
                tx_flags = tcpfsm_pkg::FLAGS_SYN_ACK;
              end
            end
            tcpfsm_pkg::ST_CONNECTING: begin
              if (rst || fin) begin
                emit = 1'b0;
              end else if (syn && ack) begin
                if (syn_ack_ok) begin
                  emit     = 1'b1;
                  tx_flags = tcpfsm_pkg::FLAGS_ACK;
                  wake     = 1'b1;
                end
              end else begin
                emit     = 1'b1;
                advance  = 1'b1;
                tx_flags = tcpfsm_pkg::FLAGS_FIN;
              end
            end
            tcpfsm_pkg::ST_SYN_RECEIVED: begin
              if (!rst && !fin && ack) begin
                wake = 1'b1;
              end
            end
            tcpfsm_pkg::ST_ESTABLISHED: begin
              if (rst) begin
                emit     = 1'b1;
                advance  = 1'b1;
                tx_flags = tcpfsm_pkg::FLAGS_FIN;
              end else if (fin) begin
                emit     = 1'b1;
                tx_flags = tcpfsm_pkg::FLAGS_ACK;
              end
            end
            tcpfsm_pkg::ST_FIN_WAIT1: begin
              if (fin) begin
                emit     = 1'b1;
                tx_flags = tcpfsm_pkg::FLAGS_ACK;
              end
            end
            tcpfsm_pkg::ST_FIN_ACKED: begin
              if (fin) begin
                emit     = 1'b1;
                tx_flags = tcpfsm_pkg::FLAGS_ACK;
              end
            end
            tcpfsm_pkg::ST_CLOSING: begin
              if (ack) begin
                wake = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
    endcase
  end

  // Sequence, ack and peer port updates
  always_comb begin
    seq_base = (s1_op_r == tcpfsm_pkg::OP_CONNECT) ? init_seq_r : send_seq_r;
    if (advance) begin
      send_seq_nxt = seq_base + 32'd1;
    end else if (s1_op_r == tcpfsm_pkg::OP_LISTEN) begin
      send_seq_nxt = init_seq_r;
    end else begin
      send_seq_nxt = send_seq_r;
    end
    ack_num_nxt   = ack_load  ? (s1_seq_r + 32'd1) : ack_num_r;
    peer_port_nxt = port_load ? s1_port_r : peer_port_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_state_r <= tcpfsm_pkg::ST_CLOSED;
      send_seq_r   <= '0;
      ack_num_r    <= '0;
      peer_port_r  <= '0;
    end else if (s1_adv) begin
      conn_state_r <= conn_state_nxt;
      send_seq_r   <= send_seq_nxt;
      ack_num_r    <= ack_num_nxt;
      peer_port_r  <= peer_port_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic        send_valid_r;
  logic [3:0]  send_flags_r;
  logic [31:0] send_seq_out_r;
  logic [31:0] send_ack_out_r;
  logic [3:0]  state_out_r;
  logic        deliver_r;
  logic        wake_r;
  logic [15:0] peer_port_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      send_valid_r    <= emit;
      send_flags_r    <= emit ? tx_flags : tcpfsm_pkg::FLAGS_NONE;
      send_seq_out_r  <= emit ? seq_base : 32'd0;
      send_ack_out_r  <= emit ? ack_num_nxt : 32'd0;
      state_out_r     <= conn_state_nxt;
      deliver_r       <= deliver;
      wake_r          <= wake;
      peer_port_out_r <= peer_port_nxt;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_send_valid           = send_valid_r;
  assign out_send_flags           = send_flags_r;
  assign out_send_sequence_out    = send_seq_out_r;
  assign out_send_acknowledge_out = send_ack_out_r;
  assign out_state_out            = state_out_r;
  assign out_deliver_payload      = deliver_r;
  assign out_wake_caller          = wake_r;
  assign out_peer_port_out        = peer_port_out_r;

endmodule

FILE: design/tcpfsm_checker.sv
// ----------------------------------------------------------------------------
// tcpfsm_checker
// Port-level checks on the TCP connection control unit, bound to its top.
// ----------------------------------------------------------------------------
module tcpfsm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_send_valid,
  input logic [3:0]  out_send_flags,
  input logic [31:0] out_send_sequence_out,
  input logic [31:0] out_send_acknowledge_out,
  input logic [3:0]  out_state_out,
  input logic        out_deliver_payload,
  input logic        out_wake_caller
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_send_flags)
      && $stable(out_state_out) && $stable(out_send_sequence_out))
    else $error("result word changed while stalled");

  // No segment means zeroed segment fields
  a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_send_valid |-> out_send_flags == 4'd0
      && out_send_sequence_out == 32'd0 && out_send_acknowledge_out == 32'd0)
    else $error("segment fields not zero without a segment");

  // Delivery only in established, and never with a control segment or a wake
  a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_deliver_payload |->
      out_state_out == tcpfsm_pkg::ST_ESTABLISHED && !out_send_valid && !out_wake_caller)
    else $error("payload delivered outside established");

  // A released caller lands in established or closed
  a_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wake_caller |->
      out_state_out == tcpfsm_pkg::ST_ESTABLISHED || out_state_out == tcpfsm_pkg::ST_CLOSED)
    else $error("wake in unexpected state");

endmodule

bind tcp_connection_fsm_unit tcpfsm_checker u_tcpfsm_checker (
  .clk                      (clk),
  .rst_n                    (rst_n),
  .out_valid                (out_valid),
  .out_ready                (out_ready),
  .out_send_valid           (out_send_valid),
  .out_send_flags           (out_send_flags),
  .out_send_sequence_out    (out_send_sequence_out),
  .out_send_acknowledge_out (out_send_acknowledge_out),
  .out_state_out            (out_state_out),
  .out_deliver_payload      (out_deliver_payload),
  .out_wake_caller          (out_wake_caller)
);
